/* hdl/epc_pkg.sv */
// Shared types, constants and helpers for the elastic point chain.
// Used by every module under hdl/; depends on nothing else.
package epc_pkg;

  localparam int NUM_POINTS = 32;
  localparam int IDX_W      = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  // Per-point coefficient steps, Q0.16
  localparam int GAIN_STEP  = 4588;   // 0.07
  localparam int DAMP_STEP  = 1311;   // 0.02
  localparam int KSTEP_W    = 29;     // 16-bit base times GAIN_STEP
  localparam int ACC_W      = 34 + IDX_W;

  localparam logic [15:0] STIFF_RESET = 16'd3277;
  localparam logic [15:0] DAMP_RESET  = 16'd58982;

  // Loudness: (|dx|+|dy|) * 7 / 5400, rounded; reciprocal is exact below the limit
  localparam int          LEVEL_HALF  = 2700;
  localparam longint      LEVEL_LIMIT = 64'd65536 * 64'd5400;
  localparam int          LEVEL_T_W   = 29;
  localparam int          RECIP_W     = 30;
  localparam logic [29:0] LEVEL_RECIP = 30'd814453058;  // ceil(2^42 / 5400)
  localparam int          LEVEL_SHIFT = 42;

  // Configuration register indexes
  localparam int          CFG_IDX_W       = 2;
  localparam logic [1:0]  REG_STIFFNESS   = 2'd0;
  localparam logic [1:0]  REG_DAMPING     = 2'd1;

  // Input word kinds
  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [31:0] depth;
  } in_word_t;

  typedef struct packed {
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [15:0] level;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
  } cell_t;

  typedef struct packed {
    logic shift;
    logic snap;
  } chain_ctrl_t;

  typedef struct packed {
    logic lead_load;
    logic pull;
    logic move;
  } upd_ctrl_t;

  typedef struct packed {
    logic sum;
    logic scale;
    logic mul;
  } level_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SCALE,
    ST_RECIP,
    ST_PULL,
    ST_MOVE,
    ST_FLUSH
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sh0080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/elastic_point_chain_core.sv */
// Top level of the elastic point chain: control sequencer, config registers,
// output register. Depends on epc_pkg, epc_chain, epc_update, epc_level.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one word per
//   item. A step word (kind 0) moves every point one spring step toward its
//   leader (target or prior point) and yields NUM_POINTS output words in
//   chain order, the final one with last set. A stop word (kind 1) snaps
//   all points to the target and clears their velocities in the cycle it is
//   taken; it yields nothing. Output channel (out_valid_o / out_stall_i /
//   out_data_o) carries one point per word from a single output register.
//   Flow: a step holds the input stalled from acceptance until the ring
//   write-back of its last point, so a new word is taken only once the core
//   is idle again. The step time is set by the one shared update unit: each
//   point passes through a pull state and a move state, since each point
//   needs the fresh position of the one before it. The SUM, SCALE and RECIP
//   states first compute the loudness level; a trailing FLUSH state writes
//   the last point back into the ring. A stop word leaves the input unstalled.
//   A stall on the output holds the sequencer in place; nothing is lost.
//   Reset clears all positions and velocities to zero and loads the default
//   stiffness and damping. Config writes land at once; write only while idle.
module elastic_point_chain_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  epc_pkg::in_word_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output epc_pkg::out_word_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic [epc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [15:0]                      cfg_data_i
);
  import epc_pkg::*;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  pt_q, pt_d;
  in_word_t          in_q;
  logic [15:0]       stiff_q, dbase_q;
  logic [KSTEP_W-1:0] kstep_q;
  logic [ACC_W-1:0]  accb_q, accb_nxt;
  logic [15:0]       gain_q, damp_q, damp_nxt;
  out_word_t         out_q;
  logic              out_valid_q;

  logic              in_accept, out_free, move_go, pt_last;
  chain_ctrl_t       chain_ctrl;
  upd_ctrl_t         upd_ctrl;
  level_ctrl_t       lvl_ctrl;
  cell_t             head, retire;
  logic [31:0]       new_x, new_y;
  logic [15:0]       level;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign move_go    = (state_q == ST_MOVE) && out_free;
  assign pt_last    = (pt_q == IDX_W'(NUM_POINTS - 1));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= STIFF_RESET;
      dbase_q <= DAMP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STIFFNESS: stiff_q <= cfg_data_i;
        REG_DAMPING:   dbase_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d          = state_q;
    pt_d             = pt_q;
    chain_ctrl.shift = 1'b0;
    chain_ctrl.snap  = in_accept && (in_data_i.kind == KIND_STOP);
    upd_ctrl         = '0;
    lvl_ctrl         = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_data_i.kind == KIND_STEP)) begin
          state_d = ST_SUM;
          pt_d    = '0;
        end
      end
      ST_SUM: begin
        lvl_ctrl.sum       = 1'b1;
        upd_ctrl.lead_load = 1'b1;
        state_d            = ST_SCALE;
      end
      ST_SCALE: begin
        lvl_ctrl.scale = 1'b1;
        state_d        = ST_RECIP;
      end
      ST_RECIP: begin
        lvl_ctrl.mul = 1'b1;
        state_d      = ST_PULL;
      end
      ST_PULL: begin
        // head leaves for the update unit; tail takes the previous point back
        upd_ctrl.pull    = 1'b1;
        chain_ctrl.shift = 1'b1;
        state_d          = ST_MOVE;
      end
      ST_MOVE: begin
        if (out_free) begin
          upd_ctrl.move = 1'b1;
          pt_d          = pt_q + IDX_W'(1);
          state_d       = pt_last ? ST_FLUSH : ST_PULL;
        end
      end
      ST_FLUSH: begin
        chain_ctrl.shift = 1'b1;
        state_d          = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pt_q    <= '0;
    end else begin
      state_q <= state_d;
      pt_q    <= pt_d;
    end
  end

  // Per-point gain and damping, stepped along the chain
  assign accb_nxt = accb_q + ACC_W'(kstep_q);
  assign damp_nxt = (damp_q >= 16'(DAMP_STEP)) ? damp_q - 16'(DAMP_STEP) : '0;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (state_q == ST_SUM) begin
      kstep_q <= KSTEP_W'(stiff_q) * KSTEP_W'(GAIN_STEP);
      damp_q  <= dbase_q;
    end
    if (state_q == ST_SCALE) begin
      accb_q <= ACC_W'(kstep_q) + ACC_W'(32768);
    end
    if (state_q == ST_RECIP) begin
      gain_q <= (|accb_q[ACC_W-1:32]) ? 16'hFFFF : accb_q[31:16];
    end
    if (move_go) begin
      accb_q <= accb_nxt;
      gain_q <= (|accb_nxt[ACC_W-1:32]) ? 16'hFFFF : accb_nxt[31:16];
      damp_q <= damp_nxt;
    end
  end

  epc_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (chain_ctrl),
    .tail_i   (retire),
    .snap_x_i (in_data_i.target_x),
    .snap_y_i (in_data_i.target_y),
    .head_o   (head)
  );

  epc_update u_update (
    .clk_i      (clk_i),
    .ctrl_i     (upd_ctrl),
    .target_x_i (in_q.target_x),
    .target_y_i (in_q.target_y),
    .head_i     (head),
    .gain_i     (gain_q),
    .damp_i     (damp_q),
    .new_x_o    (new_x),
    .new_y_o    (new_y),
    .retire_o   (retire)
  );

  epc_level u_level (
    .clk_i      (clk_i),
    .ctrl_i     (lvl_ctrl),
    .target_x_i (in_q.target_x),
    .target_y_i (in_q.target_y),
    .head_x_i   (head.pos_x),
    .head_y_i   (head.pos_y),
    .level_o    (level)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_go) begin
      out_q.point_x <= new_x;
      out_q.point_y <= new_y;
      out_q.point_z <= in_q.depth;
      out_q.level   <= level;
      out_q.last    <= pt_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The final point of a run is followed by the ring write-back
  a_last_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move_go && pt_last) |=> (state_q == ST_FLUSH && out_q.last && out_valid_q))
    else $error("last point not followed by write-back");

  // Level holds for the whole run
  a_level_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE) |-> $stable(level))
    else $error("level changed during a run");

  // A new word never overwrites one still stalled at the output
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !upd_ctrl.move)
    else $error("output word overwritten while stalled");

  // Snap only while no run is in flight
  a_snap_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_ctrl.snap |-> (state_q == ST_IDLE))
    else $error("snap outside idle");

endmodule

/* hdl/epc_cell.sv */
// One storage cell of the point ring: position and velocity of one point.
// Depends on epc_pkg.
module epc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  epc_pkg::chain_ctrl_t ctrl_i,
  input  epc_pkg::cell_t      shift_in_i,
  input  logic [31:0]         snap_x_i,
  input  logic [31:0]         snap_y_i,
  output epc_pkg::cell_t      cell_o
);
  import epc_pkg::*;

  cell_t cell_q, cell_d;

  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.snap) begin
      cell_d.pos_x = snap_x_i;
      cell_d.pos_y = snap_y_i;
      cell_d.vel_x = '0;
      cell_d.vel_y = '0;
    end else if (ctrl_i.shift) begin
      cell_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* hdl/epc_chain.sv */
// Ring of NUM_POINTS cells; advances one place toward the head per shift.
// Depends on epc_pkg and epc_cell.
module epc_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  epc_pkg::chain_ctrl_t ctrl_i,
  input  epc_pkg::cell_t       tail_i,
  input  logic [31:0]          snap_x_i,
  input  logic [31:0]          snap_y_i,
  output epc_pkg::cell_t       head_o
);
  import epc_pkg::*;

  cell_t cells [NUM_POINTS];

  for (genvar k = 0; k < NUM_POINTS; k++) begin : g_cell
    cell_t nb;
    if (k == NUM_POINTS - 1) begin : g_tail
      assign nb = tail_i;
    end else begin : g_mid
      assign nb = cells[k+1];
    end
    epc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .shift_in_i (nb),
      .snap_x_i   (snap_x_i),
      .snap_y_i   (snap_y_i),
      .cell_o     (cells[k])
    );
  end

  assign head_o = cells[0];

endmodule

/* hdl/epc_update.sv */
// Shared spring update unit: pull, velocity and position for one point,
// then velocity damping while the next point is pulled. Depends on epc_pkg.
module epc_update (
  input  logic               clk_i,
  input  epc_pkg::upd_ctrl_t ctrl_i,
  input  logic [31:0]        target_x_i,
  input  logic [31:0]        target_y_i,
  input  epc_pkg::cell_t     head_i,
  input  logic [15:0]        gain_i,
  input  logic [15:0]        damp_i,
  output logic [31:0]        new_x_o,
  output logic [31:0]        new_y_o,
  output epc_pkg::cell_t     retire_o
);
  import epc_pkg::*;

  function automatic logic signed [33:0] pull_of(input logic signed [32:0] d,
                                                  input logic [15:0] g);
    logic signed [49:0] p;
    p = 50'(d) * $signed({34'd0, g}) + 50'sd32768;
    return p[49:16];
  endfunction

  function automatic logic signed [31:0] damp_of(input logic signed [31:0] v,
                                                  input logic [15:0] d);
    logic signed [47:0] p;
    // |v * d| stays below 2^47, so the rounded result always fits 32 bits
    p = 48'(v) * $signed({32'd0, d}) + 48'sd32768;
    return p[47:16];
  endfunction

  logic signed [31:0] lead_x_q, lead_y_q;
  logic signed [33:0] pull_x_q, pull_y_q;
  logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic signed [31:0] vsum_x_q, vsum_y_q, pnew_x_q, pnew_y_q;
  logic [15:0]        rdamp_q;

  logic signed [32:0] diff_x, diff_y;
  logic signed [31:0] vs_x, vs_y, pn_x, pn_y;

  assign diff_x = 33'(lead_x_q) - 33'($signed(head_i.pos_x));
  assign diff_y = 33'(lead_y_q) - 33'($signed(head_i.pos_y));

  assign vs_x = sat32(40'(vel_x_q) + 40'(pull_x_q));
  assign vs_y = sat32(40'(vel_y_q) + 40'(pull_y_q));
  assign pn_x = sat32(40'(pos_x_q) + 40'(vs_x));
  assign pn_y = sat32(40'(pos_y_q) + 40'(vs_y));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lead_load) begin
      lead_x_q <= $signed(target_x_i);
      lead_y_q <= $signed(target_y_i);
    end else if (ctrl_i.move) begin
      // next point follows this one's fresh position
      lead_x_q <= pn_x;
      lead_y_q <= pn_y;
    end
    if (ctrl_i.pull) begin
      pull_x_q <= pull_of(diff_x, gain_i);
      pull_y_q <= pull_of(diff_y, gain_i);
      pos_x_q  <= $signed(head_i.pos_x);
      pos_y_q  <= $signed(head_i.pos_y);
      vel_x_q  <= $signed(head_i.vel_x);
      vel_y_q  <= $signed(head_i.vel_y);
    end
    if (ctrl_i.move) begin
      vsum_x_q <= vs_x;
      vsum_y_q <= vs_y;
      pnew_x_q <= pn_x;
      pnew_y_q <= pn_y;
      rdamp_q  <= damp_i;
    end
  end

  assign new_x_o = pn_x;
  assign new_y_o = pn_y;

  always_comb begin
    retire_o.pos_x = pnew_x_q;
    retire_o.pos_y = pnew_y_q;
    retire_o.vel_x = damp_of(vsum_x_q, rdamp_q);
    retire_o.vel_y = damp_of(vsum_y_q, rdamp_q);
  end

endmodule

/* hdl/epc_level.sv */
// Loudness from the first raw pull: sum of distances, scale, reciprocal
// multiply, each registered in turn. Depends on epc_pkg.
module epc_level (
  input  logic                 clk_i,
  input  epc_pkg::level_ctrl_t ctrl_i,
  input  logic [31:0]          target_x_i,
  input  logic [31:0]          target_y_i,
  input  logic [31:0]          head_x_i,
  input  logic [31:0]          head_y_i,
  output logic [15:0]          level_o
);
  import epc_pkg::*;

  logic signed [32:0]     dx, dy;
  logic [32:0]            adx, ady;
  logic [33:0]            sum_q;
  logic [36:0]            t_full;
  logic [LEVEL_T_W-1:0]   t_q;
  logic                   sat_q;
  logic [LEVEL_T_W+RECIP_W-1:0] prod;
  logic [15:0]            lvl_q;

  assign dx  = 33'($signed(target_x_i)) - 33'($signed(head_x_i));
  assign dy  = 33'($signed(target_y_i)) - 33'($signed(head_y_i));
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);

  // times seven as eight minus one, plus half the divisor for rounding
  assign t_full = {sum_q, 3'b000} - {3'b000, sum_q} + 37'(LEVEL_HALF);
  assign prod   = (LEVEL_T_W+RECIP_W)'(t_q) * (LEVEL_T_W+RECIP_W)'(LEVEL_RECIP);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum) begin
      sum_q <= {1'b0, adx} + {1'b0, ady};
    end
    if (ctrl_i.scale) begin
      sat_q <= (t_full >= 37'(LEVEL_LIMIT));
      t_q   <= t_full[LEVEL_T_W-1:0];
    end
    if (ctrl_i.mul) begin
      lvl_q <= sat_q ? 16'hFFFF : prod[LEVEL_SHIFT+15:LEVEL_SHIFT];
    end
  end

  assign level_o = lvl_q;

endmodule

/* sim/elastic_point_chain_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for elastic_point_chain_core: step and stop words, config phases
// and receiver hold-off, all checked against an in-bench spring chain predictor.
// Depends on epc_pkg and elastic_point_chain_core.
module elastic_point_chain_core_tb;
  import epc_pkg::*;

  localparam int SETTLE_CYCLES = 2 * NUM_POINTS + 8;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_AFTER    = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_MAX    = 10;
  localparam int PHASE_WORDS   = 65;
  localparam int NUM_PHASES    = 6;
  localparam int CALM_PHASE    = 3;
  localparam int IN_W          = $bits(in_word_t);

  localparam longint LOUD_NUM  = 7;
  localparam longint LOUD_DEN  = 5400;
  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } axis_state_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_word_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_word_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [15:0]          cfg_data_i  = '0;

  // Predictor state and register copies
  int          chain_x [NUM_POINTS];
  int          chain_y [NUM_POINTS];
  int          speed_x [NUM_POINTS];
  int          speed_y [NUM_POINTS];
  logic [15:0] stiff_q16;
  logic [15:0] damp_q16;

  in_word_t    word_q[$];
  out_word_t   point_q[$];

  int   fault_count = 0;
  int   words_taken = 0;
  int   in_gap_pct  = 10;
  int   out_gap_pct = 10;
  int   hold_left   = 0;
  logic hold_done   = 1'b0;
  int   aim_x       = 0;
  int   aim_y       = 0;

  elastic_point_chain_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp_s32(longint v);
    if (v > S32_MAX) return 32'sh7FFF_FFFF;
    if (v < S32_MIN) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // Q16.16 times Q0.16, round half up
  function automatic longint scale_q16(longint v, longint c);
    return (v * c + 64'sd32768) >>> 16;
  endfunction

  function automatic axis_state_t spring_axis(longint lead, int pos, int vel, longint g,
                                              longint d);
    int          nv;
    axis_state_t r;
    nv    = clamp_s32(longint'(vel) + scale_q16(lead - longint'(pos), g));
    r.pos = clamp_s32(longint'(pos) + longint'(nv));
    r.vel = clamp_s32(scale_q16(longint'(nv), d));
    return r;
  endfunction

  // Update the chain for one accepted word and queue the points it yields
  function automatic void advance_chain(in_word_t w);
    int          tx, ty;
    longint      dx, dy, lvl, g, d, dec, lead_x, lead_y;
    axis_state_t ax, ay;
    out_word_t   o;
    tx = int'(w.target_x);
    ty = int'(w.target_y);
    if (w.kind == KIND_STOP) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        chain_x[i] = tx;
        chain_y[i] = ty;
        speed_x[i] = 0;
        speed_y[i] = 0;
      end
    end else begin
      dx = longint'(tx) - longint'(chain_x[0]);
      dy = longint'(ty) - longint'(chain_y[0]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      lvl = ((dx + dy) * LOUD_NUM + LOUD_DEN / 2) / LOUD_DEN;
      if (lvl > 65535) lvl = 65535;
      for (int i = 0; i < NUM_POINTS; i++) begin
        g = (longint'(stiff_q16) * GAIN_STEP * (i + 1) + 32768) >>> 16;
        if (g > 65535) g = 65535;
        dec = longint'(DAMP_STEP) * i;
        d   = (dec >= longint'(damp_q16)) ? 64'sd0 : longint'(damp_q16) - dec;
        lead_x = (i == 0) ? longint'(tx) : longint'(chain_x[i-1]);
        lead_y = (i == 0) ? longint'(ty) : longint'(chain_y[i-1]);
        ax = spring_axis(lead_x, chain_x[i], speed_x[i], g, d);
        ay = spring_axis(lead_y, chain_y[i], speed_y[i], g, d);
        chain_x[i] = ax.pos;
        speed_x[i] = ax.vel;
        chain_y[i] = ay.pos;
        speed_y[i] = ay.vel;
        o.point_x  = ax.pos;
        o.point_y  = ay.pos;
        o.point_z  = w.depth;
        o.level    = lvl[15:0];
        o.last     = (i == NUM_POINTS - 1);
        point_q.push_back(o);
      end
    end
  endfunction

  function automatic void check_point(out_word_t got);
    out_word_t want;
    if (point_q.size() == 0) begin
      fault_count++;
      if (fault_count <= REPORT_MAX)
        $display("[%0t] point word with nothing expected: x %h y %h z %h level %h last %b",
                 $time, got.point_x, got.point_y, got.point_z, got.level, got.last);
    end else begin
      want = point_q.pop_front();
      if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.point_z !== want.point_z || got.level !== want.level ||
          got.last !== want.last) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("[%0t] exp/act: x %h/%h y %h/%h z %h/%h level %h/%h last %b/%b",
                   $time, want.point_x, got.point_x, want.point_y, got.point_y,
                   want.point_z, got.point_z, want.level, got.level, want.last, got.last);
      end
    end
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(3))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic void offer(logic kind, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_word_t w;
    w.kind     = kind;
    w.target_x = x;
    w.target_y = y;
    w.depth    = z;
    word_q.push_back(w);
  endfunction

  // Mostly small moves around a drifting target so the chain settles and follows
  function automatic void queue_random(int count);
    in_word_t w;
    int       roll;
    for (int n = 0; n < count; n++) begin
      roll   = $urandom_range(99);
      w.kind = ($urandom_range(99) < 12) ? KIND_STOP : KIND_STEP;
      if (roll < 55) begin
        aim_x += int'($urandom_range(2097152)) - 1048576;
        aim_y += int'($urandom_range(2097152)) - 1048576;
      end else if (roll < 75) begin
        aim_x = int'($urandom);
        aim_y = int'($urandom);
      end else if (roll < 87) begin
        aim_x = int'(pick_extreme());
        aim_y = int'(pick_extreme());
      end else begin
        aim_x = int'($urandom_range(131072)) - 65536;
        aim_y = int'($urandom_range(131072)) - 65536;
      end
      w.target_x = aim_x;
      w.target_y = aim_y;
      w.depth    = ($urandom_range(9) == 0) ? pick_extreme() : $urandom;
      word_q.push_back(w);
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_STIFFNESS) stiff_q16 = val;
    else if (idx == REG_DAMPING) damp_q16 = val;
    @(negedge clk_i);
  endtask

  // Wait until every word is taken and every point is back, then let the core go idle
  task automatic drain();
    while (word_q.size() != 0 || in_valid_i || point_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sender: hold a stalled word, otherwise offer the next one or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_chain(in_data_i);
        words_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (word_q.size() != 0 && $urandom_range(99) >= in_gap_pct) begin
          in_data_i  <= word_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_data_i  <= IN_W'({$urandom, $urandom, $urandom, $urandom});
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each point, stall at random, hold off once for a long stretch
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_point(out_data_o);
      if (!hold_done && words_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_gap_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [15:0] stiff_pick;
    logic [15:0] damp_pick;
    for (int i = 0; i < NUM_POINTS; i++) begin
      chain_x[i] = 0;
      chain_y[i] = 0;
      speed_x[i] = 0;
      speed_y[i] = 0;
    end
    stiff_q16 = STIFF_RESET;
    damp_q16  = DAMP_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default gains: zero pull, full-scale and opposite-corner jumps, tiny pull
    offer(KIND_STEP, 32'h0, 32'h0, 32'h0);
    offer(KIND_STEP, Q_MAX, Q_MAX, Q_MAX);
    offer(KIND_STEP, Q_MIN, Q_MIN, Q_MIN);
    offer(KIND_STOP, Q_MAX, Q_MIN, 32'h0);
    offer(KIND_STEP, Q_MIN, Q_MAX, 32'h5555_5555);
    offer(KIND_STOP, 32'h0, 32'h0, 32'hFFFF_FFFF);
    offer(KIND_STEP, 32'h0000_0001, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
    offer(KIND_STEP, 32'h0001_0000, 32'h0, 32'h0001_0000);
    drain();

    // Full-scale stiffness and damping base: drive velocity and position into clamping
    write_reg(REG_STIFFNESS, 16'hFFFF);
    write_reg(REG_DAMPING, 16'hFFFF);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h1234);
    offer(KIND_STOP, Q_MIN, Q_MIN, 32'h0);
    offer(KIND_STEP, Q_MAX, Q_MAX, 32'h0);
    offer(KIND_STEP, Q_MAX, Q_MAX, 32'h0);
    offer(KIND_STEP, Q_MIN, Q_MIN, 32'h0);
    offer(KIND_STEP, Q_MIN, Q_MIN, 32'h0);
    offer(KIND_STEP, Q_MAX, Q_MIN, 32'h0);
    drain();

    // Zero gain and zero retention: leftover velocity moves once, then nothing
    write_reg(REG_STIFFNESS, 16'h0000);
    write_reg(REG_DAMPING, 16'h0000);
    offer(KIND_STEP, Q_MAX, Q_MAX, 32'h0);
    offer(KIND_STEP, 32'h0, 32'h0, 32'h0);
    offer(KIND_STOP, 32'h1234_5678, 32'hFEDC_BA98, 32'h0);
    offer(KIND_STEP, 32'h0, 32'h0, 32'h0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          stiff_pick = 16'($urandom);
          damp_pick  = 16'($urandom);
        end
        1: begin
          stiff_pick = 16'hFFFF;
          damp_pick  = 16'h0000;
        end
        2: begin
          stiff_pick = 16'h0000;
          damp_pick  = 16'hFFFF;
        end
        CALM_PHASE: begin
          stiff_pick = STIFF_RESET;
          damp_pick  = DAMP_RESET;
        end
        4: begin
          stiff_pick = 16'($urandom_range(8000));
          damp_pick  = 16'($urandom_range(65535, 40000));
        end
        default: begin
          stiff_pick = 16'($urandom);
          damp_pick  = 16'($urandom);
        end
      endcase
      in_gap_pct  = (p == CALM_PHASE) ? 0 : 10;
      out_gap_pct = (p == CALM_PHASE) ? 0 : 10;
      write_reg(REG_STIFFNESS, stiff_pick);
      write_reg(REG_DAMPING, damp_pick);
      write_reg((p % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
      queue_random(PHASE_WORDS);
      drain();
    end

    if (fault_count == 0 && point_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/epc_pkg.sv
hdl/epc_cell.sv
hdl/epc_chain.sv
hdl/epc_update.sv
hdl/epc_level.sv
hdl/elastic_point_chain_core.sv
sim/elastic_point_chain_core_tb.sv
